// ===== src/nas_pkg.sv =====
`default_nettype none

package nas_pkg;

   // Field widths
   localparam int SLOT_W    = 4;
   localparam int HOUR_W    = 5;
   localparam int MINUTE_W  = 6;
   localparam int MASK_W    = 7;
   localparam int WDAY_W    = 3;
   localparam int TIME_W    = 11;   // hour*60+minute, at most 1923
   localparam int DELAY_W   = 14;
   localparam int DAYS_W    = 3;

   // Time constants
   localparam int MIN_PER_HOUR  = 60;
   localparam int DAYS_PER_WEEK = 7;
   localparam int SUNDAY_MON    = 6;      // Sunday in Monday-first numbering
   localparam int MIN_PER_DAY   = 24 * 60;

   // Command codes
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef struct packed {
      logic                cmd;
      logic [SLOT_W-1:0]   slot;
      logic                enable;
      logic [HOUR_W-1:0]   ring_hour;
      logic [MINUTE_W-1:0] ring_minute;
      logic [MASK_W-1:0]   repeat_mask;
      logic [WDAY_W-1:0]   clock_weekday;
      logic [HOUR_W-1:0]   clock_hour;
      logic [MINUTE_W-1:0] clock_minute;
   } nas_req_type;

   typedef struct packed {
      logic               found;
      logic [SLOT_W-1:0]  best_slot;
      logic [DELAY_W-1:0] minutes_to_ring;
      logic [DAYS_W-1:0]  day_offset;
   } nas_rsp_type;

   // One stored alarm, ring time kept in minutes of the day
   typedef struct packed {
      logic              enable;
      logic [TIME_W-1:0] at_min;
      logic [MASK_W-1:0] repeat_mask;
   } nas_entry_type;

   // Query context broadcast to every cell
   typedef struct packed {
      logic [WDAY_W-1:0] wday_mon;
      logic [TIME_W-1:0] now_min;
   } nas_ctx_type;

   function automatic logic [TIME_W-1:0] day_minutes(
      input logic [HOUR_W-1:0]   hour,
      input logic [MINUTE_W-1:0] minute
   );
      return TIME_W'(TIME_W'(hour) * TIME_W'(MIN_PER_HOUR) + TIME_W'(minute));
   endfunction

   // Sunday-first weekday to Monday-first; weekday seven counts as Sunday
   function automatic logic [WDAY_W-1:0] to_monday_first(input logic [WDAY_W-1:0] wday);
      logic [WDAY_W-1:0] res;
      unique case (wday)
         3'd0:    res = WDAY_W'(SUNDAY_MON);
         3'd1:    res = 3'd0;
         3'd2:    res = 3'd1;
         3'd3:    res = 3'd2;
         3'd4:    res = 3'd3;
         3'd5:    res = 3'd4;
         3'd6:    res = 3'd5;
         default: res = WDAY_W'(SUNDAY_MON);
      endcase
      return res;
   endfunction

endpackage

`default_nettype wire

// ===== src/next_alarm_selector_unit.sv =====
`default_nettype none

// Channel   Direction  Beat            Handshake
// req       in         nas_req_type    req_valid / req_ready
// rsp       out        nas_rsp_type    rsp_valid / rsp_ready
//
// A write beat updates its slot's cell on the edge that accepts it.
// A query runs through a chain of ALARM_SLOTS cells, one cell per cycle while
// the chain is not held, and its result is then loaded into the output register.
// req_ready drops while a query is in the chain; a pending result does not
// block the next beat. If the result register is still full when a query
// reaches the end, the chain holds until rsp is taken.
// Reset (synchronous) disables every slot and empties the chain.
module next_alarm_selector_unit #(
   parameter int ALARM_SLOTS = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire nas_pkg::nas_req_type req_data,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output nas_pkg::nas_rsp_type     rsp_data
);
   import nas_pkg::*;

   logic          busy_ff;
   logic          busy_in;
   logic          start_ff;
   logic          start_in;
   nas_ctx_type   ctx_ff;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   nas_rsp_type   rsp_data_ff;

   logic          req_fire;
   logic          wr_en;
   logic          query_fire;
   logic          advance;
   logic          rsp_load;
   nas_entry_type wr_entry;

   logic          chain_valid [0:ALARM_SLOTS];
   nas_rsp_type   chain_best  [0:ALARM_SLOTS];

   assign req_ready  = !busy_ff;
   assign req_fire   = req_valid && req_ready;
   assign wr_en      = req_fire && req_data.cmd == CMD_WRITE;
   assign query_fire = req_fire && req_data.cmd == CMD_QUERY;

   // Convert the ring time to minutes of the day once, at write time
   always_comb begin
      wr_entry.enable      = req_data.enable;
      wr_entry.at_min      = day_minutes(req_data.ring_hour, req_data.ring_minute);
      wr_entry.repeat_mask = req_data.repeat_mask;
   end

   // Hold the whole chain when the finished query cannot leave
   assign advance  = !(chain_valid[ALARM_SLOTS] && rsp_valid_ff && !rsp_ready);
   assign rsp_load = chain_valid[ALARM_SLOTS] && advance;

   // Inject an empty best-so-far at the head of the chain
   assign chain_valid[0] = start_ff;
   assign chain_best[0]  = '0;

   for (genvar i = 0; i < ALARM_SLOTS; i++) begin : g_cell
      nas_cell #(
         .INDEX(i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .wr_en     (wr_en),
         .wr_slot   (req_data.slot),
         .wr_entry  (wr_entry),
         .ctx       (ctx_ff),
         .in_valid  (chain_valid[i]),
         .in_best   (chain_best[i]),
         .out_valid (chain_valid[i+1]),
         .out_best  (chain_best[i+1])
      );
   end

   always_comb begin
      busy_in = busy_ff;
      if (query_fire) begin
         busy_in = 1'b1;
      end else if (rsp_load) begin
         busy_in = 1'b0;
      end

      start_in = start_ff;
      if (query_fire) begin
         start_in = 1'b1;
      end else if (advance) begin
         start_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture the query time; it stays put until the next query
   always_ff @(posedge clock) begin
      if (query_fire) begin
         ctx_ff.wday_mon <= to_monday_first(req_data.clock_weekday);
         ctx_ff.now_min  <= day_minutes(req_data.clock_hour, req_data.clock_minute);
      end
      if (rsp_load) begin
         rsp_data_ff <= chain_best[ALARM_SLOTS];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== src/nas_cell.sv =====
`default_nettype none

module nas_cell #(
   parameter int INDEX = 0
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  advance,
   input  wire logic                  wr_en,
   input  wire logic [3:0]            wr_slot,
   input  wire nas_pkg::nas_entry_type wr_entry,
   input  wire nas_pkg::nas_ctx_type  ctx,
   input  wire logic                  in_valid,
   input  wire nas_pkg::nas_rsp_type  in_best,
   output logic                       out_valid,
   output nas_pkg::nas_rsp_type       out_best
);
   import nas_pkg::*;

   nas_entry_type entry_ff;
   logic          valid_ff;
   nas_rsp_type   best_ff;
   nas_rsp_type   best_in;

   logic [DAYS_W-1:0]  off;
   logic [DELAY_W-1:0] delay;
   logic [DELAY_W:0]   sum;
   logic               ahead;
   logic               hit;
   logic [3:0]         wd;
   logic               take;

   always_comb begin
      ahead = entry_ff.at_min > ctx.now_min;
      hit   = 1'b0;
      off   = DAYS_W'(DAYS_PER_WEEK);
      wd    = '0;
      if (entry_ff.repeat_mask == '0) begin
         off = ahead ? 3'd0 : 3'd1;
      end else begin
         // search forward from today for the first repeat day
         for (int k = 0; k < DAYS_PER_WEEK; k++) begin
            wd = 4'(ctx.wday_mon) + 4'(k);
            if (wd >= 4'(DAYS_PER_WEEK)) begin
               wd = wd - 4'(DAYS_PER_WEEK);
            end
            if (!hit && entry_ff.repeat_mask[wd[2:0]] && (k != 0 || ahead)) begin
               hit = 1'b1;
               off = DAYS_W'(k);
            end
         end
      end
      sum   = (DELAY_W+1)'((DELAY_W+1)'(off) * (DELAY_W+1)'(MIN_PER_DAY))
            + (DELAY_W+1)'(entry_ff.at_min) - (DELAY_W+1)'(ctx.now_min);
      // clamp a negative delay to zero
      delay = sum[DELAY_W] ? '0 : sum[DELAY_W-1:0];
      take  = entry_ff.enable && (!in_best.found || delay < in_best.minutes_to_ring);
      if (take) begin
         best_in.found           = 1'b1;
         best_in.best_slot       = SLOT_W'(INDEX);
         best_in.minutes_to_ring = delay;
         best_in.day_offset      = off;
      end else begin
         best_in = in_best;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (wr_en && 32'(wr_slot) == INDEX) begin
            entry_ff <= wr_entry;
         end
         if (advance) begin
            valid_ff <= in_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         best_ff <= best_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_best  = best_ff;

endmodule

`default_nettype wire

// ===== tb/next_alarm_selector_checker.sv =====
`default_nettype none

module next_alarm_selector_checker #(
   parameter int SLOTS = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_ready,
   input  wire nas_pkg::nas_req_type req_data,
   input  wire logic                 rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire nas_pkg::nas_rsp_type rsp_data,
   output int                        fail_count,
   output int                        pending_results
);

   timeunit 1ns;
   timeprecision 1ps;

   import nas_pkg::*;

   typedef struct packed {
      logic                enable;
      logic [HOUR_W-1:0]   hour;
      logic [MINUTE_W-1:0] minute;
      logic [MASK_W-1:0]   repeat_mask;
   } alarm_setting_type;

   alarm_setting_type alarm_book [SLOTS];
   nas_rsp_type       expected_soonest [$];
   int                mismatches = 0;

   function automatic nas_rsp_type soonest_alarm(input nas_req_type q);
      nas_rsp_type best;
      int i, k, now_min, at_min, wd_mon, offset, delay;
      best    = '0;
      wd_mon  = (int'(q.clock_weekday) + SUNDAY_MON) % DAYS_PER_WEEK;
      now_min = int'(q.clock_hour) * MIN_PER_HOUR + int'(q.clock_minute);
      for (i = 0; i < SLOTS; i++) begin
         if (alarm_book[i].enable) begin
            at_min = int'(alarm_book[i].hour) * MIN_PER_HOUR + int'(alarm_book[i].minute);
            if (alarm_book[i].repeat_mask == '0) begin
               offset = (at_min > now_min) ? 0 : 1;
            end else begin
               // walk backward so the earliest matching day is kept
               offset = DAYS_PER_WEEK;
               for (k = DAYS_PER_WEEK - 1; k >= 0; k--) begin
                  if (alarm_book[i].repeat_mask[(wd_mon + k) % DAYS_PER_WEEK] &&
                      (k != 0 || at_min > now_min))
                     offset = k;
               end
            end
            delay = offset * MIN_PER_DAY + at_min - now_min;
            if (delay < 0)
               delay = 0;
            if (!best.found || delay < int'(best.minutes_to_ring)) begin
               best.found           = 1'b1;
               best.best_slot       = SLOT_W'(i);
               best.minutes_to_ring = DELAY_W'(delay);
               best.day_offset      = DAYS_W'(offset);
            end
         end
      end
      return best;
   endfunction

   always @(posedge clock) begin
      nas_rsp_type want;
      if (reset) begin
         foreach (alarm_book[i])
            alarm_book[i] = '0;
         expected_soonest.delete();
      end else begin
         if (req_valid && req_ready) begin
            if (req_data.cmd == CMD_WRITE) begin
               if (int'(req_data.slot) < SLOTS)
                  alarm_book[req_data.slot] = '{req_data.enable, req_data.ring_hour,
                                                req_data.ring_minute, req_data.repeat_mask};
            end else begin
               expected_soonest.push_back(soonest_alarm(req_data));
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_soonest.size() == 0) begin
               $error("unexpected result beat: %p", rsp_data);
               mismatches++;
            end else begin
               want = expected_soonest.pop_front();
               if (rsp_data.found !== want.found) begin
                  $error("found: expected %0d, got %0d", want.found, rsp_data.found);
                  mismatches++;
               end
               if (rsp_data.best_slot !== want.best_slot) begin
                  $error("best_slot: expected %0d, got %0d", want.best_slot,
                         rsp_data.best_slot);
                  mismatches++;
               end
               if (rsp_data.minutes_to_ring !== want.minutes_to_ring) begin
                  $error("minutes_to_ring: expected %0d, got %0d", want.minutes_to_ring,
                         rsp_data.minutes_to_ring);
                  mismatches++;
               end
               if (rsp_data.day_offset !== want.day_offset) begin
                  $error("day_offset: expected %0d, got %0d", want.day_offset,
                         rsp_data.day_offset);
                  mismatches++;
               end
            end
         end
      end
      fail_count      <= mismatches;
      pending_results <= expected_soonest.size();
   end

endmodule

`default_nettype wire

// ===== tb/next_alarm_selector_unit_tb.sv =====
`default_nettype none

module next_alarm_selector_unit_tb;

   timeunit 1ns;
   timeprecision 1ps;

   import nas_pkg::*;

   localparam int SLOT_COUNT  = 16;
   localparam int STALL_LIMIT = 4000;   // cycles with no beat on either channel
   localparam int BLOCKS      = 17;     // random part, 100 beats per block

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   nas_req_type req_data  = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   nas_rsp_type rsp_data;

   int fail_count;
   int pending_results;
   int stall_cycles = 0;
   bit gaps_on      = 1'b1;   // random idling on both channels

   always #1 clock = ~clock;

   next_alarm_selector_unit #(
      .ALARM_SLOTS(SLOT_COUNT)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   next_alarm_selector_checker #(
      .SLOTS(SLOT_COUNT)
   ) checker_i (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data        (rsp_data),
      .fail_count      (fail_count),
      .pending_results (pending_results)
   );

   // Stall the result channel at random, with an 18 percent chance per draw while gaps are on;
   // the draw is independent of rsp_valid so stalls land on every phase.
   always @(posedge clock)
      rsp_ready <= !(gaps_on && $urandom_range(99) < 18);

   // Watchdog: count cycles with no accepted beat on either channel and give up
   // once the count reaches the limit.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Present one request beat and hold it until the block takes it. Random idle
   // cycles go in front of the beat; the beat itself never drops early.
   task automatic send_beat(input nas_req_type beat);
      while (gaps_on && $urandom_range(99) < 18) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (!req_ready);
   endtask

   // Drop valid and wait until every predicted result has come back. The first
   // clock lets the checker count a query accepted on the previous edge.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0)
         @(posedge clock);
   endtask

   // Write beats carry random junk in the query fields and vice versa, so the
   // block is seen to ignore what does not belong to the command.
   function automatic nas_req_type write_beat(input int slot, input bit en, input int hour,
                                              input int minute, input int mask);
      nas_req_type b;
      b             = nas_req_type'({$urandom, $urandom});
      b.cmd         = CMD_WRITE;
      b.slot        = SLOT_W'(slot);
      b.enable      = en;
      b.ring_hour   = HOUR_W'(hour);
      b.ring_minute = MINUTE_W'(minute);
      b.repeat_mask = MASK_W'(mask);
      return b;
   endfunction

   function automatic nas_req_type query_beat(input int wday, input int hour, input int minute);
      nas_req_type b;
      b               = nas_req_type'({$urandom, $urandom});
      b.cmd           = CMD_QUERY;
      b.clock_weekday = WDAY_W'(wday);
      b.clock_hour    = HOUR_W'(hour);
      b.clock_minute  = MINUTE_W'(minute);
      return b;
   endfunction

   // Mostly legal hours; now and then one from 24 to 31, past the end of the day.
   function automatic logic [HOUR_W-1:0] pick_hour();
      if ($urandom_range(19) == 0)
         return HOUR_W'($urandom_range(31, 24));
      return HOUR_W'($urandom_range(23));
   endfunction

   // Favor a few round minutes so alarm and clock times collide and ties occur.
   function automatic logic [MINUTE_W-1:0] pick_minute();
      case ($urandom_range(5))
         0:       return MINUTE_W'(0);
         1:       return MINUTE_W'(30);
         2:       return MINUTE_W'(59);
         3:       return MINUTE_W'($urandom_range(63, 60));
         default: return MINUTE_W'($urandom_range(59));
      endcase
   endfunction

   function automatic nas_req_type random_beat(input int enable_pct);
      nas_req_type b;
      b              = nas_req_type'({$urandom, $urandom});
      b.cmd          = ($urandom_range(99) < 45) ? CMD_WRITE : CMD_QUERY;
      b.enable       = ($urandom_range(99) < enable_pct);
      b.ring_hour    = pick_hour();
      b.ring_minute  = pick_minute();
      b.clock_hour   = pick_hour();
      b.clock_minute = pick_minute();
      case ($urandom_range(3))
         0:       b.repeat_mask = '0;
         1:       b.repeat_mask = MASK_W'(1) << $urandom_range(6);
         default: ;   // keep the random mask
      endcase
      return b;
   endfunction

   initial begin
      int enable_pct;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty table, day wrap, weekday seven, out-of-range times,
      // clamped delays, week-out repeats and lowest-slot ties.
      send_beat(query_beat(0, 12, 0));             // nothing enabled
      send_beat(write_beat(15, 1'b1, 23, 59, 0));  // one-shot, last minute of day
      send_beat(query_beat(6, 23, 59));            // same minute: tomorrow
      send_beat(query_beat(3, 0, 0));              // still ahead today
      send_beat(write_beat(0, 1'b1, 0, 0, 7'h7F)); // every day at midnight
      send_beat(query_beat(7, 0, 0));              // weekday seven as Sunday
      send_beat(write_beat(15, 1'b0, 23, 59, 0));  // disable slot 15
      send_beat(query_beat(7, 0, 0));
      send_beat(write_beat(3, 1'b1, 31, 63, 0));   // largest raw ring time
      send_beat(query_beat(2, 31, 63));            // negative delay clamps to zero
      send_beat(write_beat(0, 1'b1, 8, 0, 7'h04)); // Wednesday only
      send_beat(write_beat(3, 1'b0, 0, 0, 0));
      send_beat(query_beat(3, 9, 0));              // today passed: a week out
      send_beat(query_beat(3, 7, 59));             // today, one minute out
      send_beat(write_beat(5, 1'b1, 8, 0, 7'h40)); // Sunday only
      send_beat(query_beat(3, 9, 0));
      send_beat(write_beat(9, 1'b1, 8, 0, 7'h40)); // tie with slot 5
      send_beat(query_beat(6, 8, 0));
      send_beat(write_beat(2, 1'b1, 0, 0, 0));
      send_beat(query_beat(0, 0, 0));
      send_beat(write_beat(1, 1'b1, 31, 63, 7'h7F));
      send_beat(query_beat(1, 0, 0));              // ring time past the day length
      send_beat(query_beat(4, 31, 0));

      // Random: blocks of 100 beats with a per-block enable rate, so the table
      // fills up and drains. Blocks 5 to 7 run without idling on either side.
      for (int blk = 0; blk < BLOCKS; blk++) begin
         case ($urandom_range(2))
            0:       enable_pct = 10;
            1:       enable_pct = 50;
            default: enable_pct = 90;
         endcase
         gaps_on = !(blk >= 5 && blk <= 7);
         if (blk == 10 || $urandom_range(3) == 0)
            drain_results();
         for (int n = 0; n < 100; n++)
            send_beat(random_beat(enable_pct));
      end

      // Wind down: hold valid low, wait for the last results, then keep clocking for
      // a margin scaled to the slot count, for anything stray.
      gaps_on = 1'b1;
      drain_results();
      repeat (2 * SLOT_COUNT + 8) @(posedge clock);

      if (fail_count == 0 && pending_results == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

`default_nettype wire
